[rtl/drc_pkg.sv]
package drc_pkg;

	localparam int DEF_MAX_ATOMS = 4096;
	localparam int DEF_POS_WIDTH = 24;

	localparam int KIND_W  = 2;
	localparam int IDX_W   = 12;
	localparam int SKIN_W  = 23;
	// a component that passes the half-skin test is below 2^(SKIN_W-1)
	localparam int SQ_W    = SKIN_W - 1;
	localparam int SKIN_SQ_W = 2 * SKIN_W;
	localparam int SUM_W   = 2 * SQ_W + 2;
	localparam int ACC_W   = SUM_W + 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_STORE = 2'd0,
		KIND_CHECK = 2'd1,
		KIND_INVAL = 2'd2
	} kind_t;

	// per-item control carried alongside the position through the pipeline
	typedef struct packed {
		logic check;      // check item
		logic clr;        // store or check flagged last: ends the pass
		logic emit;       // check flagged last: gives a result
		logic in_range;   // index within the store
		logic ctrl_fail;  // list invalid or count mismatch at pass end
	} tag_t;

endpackage

[rtl/drc_ram.sv]
module drc_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

[rtl/drc_ctrl.sv]
// Pass bookkeeping: counts, stored count and list validity, settled at accept; a skin write also drops validity.
module drc_ctrl #(
	parameter int MAX_ATOMS = drc_pkg::DEF_MAX_ATOMS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [drc_pkg::KIND_W-1:0] kind,
	input  logic [drc_pkg::IDX_W-1:0]  atom_index,
	input  logic                       last,
	input  logic                       skin_we,
	output logic                       item_valid,
	output drc_pkg::tag_t              tag
);

	localparam int CW = $clog2(MAX_ATOMS + 2);
	localparam logic [CW-1:0] CAP = CW'(MAX_ATOMS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_ATOMS);

	logic [CW-1:0] pass_count_q;
	logic [CW-1:0] stored_count_q;
	logic          list_valid_q;
	logic [CW-1:0] count;
	drc_pkg::kind_t kind_c;
	logic          is_store;
	logic          is_check;

	assign kind_c   = drc_pkg::kind_t'(kind);
	assign is_store = (kind_c == drc_pkg::KIND_STORE);
	assign is_check = (kind_c == drc_pkg::KIND_CHECK);
	assign count    = (pass_count_q < CAP) ? pass_count_q + CW'(1) : CAP;

	assign item_valid    = accept && (is_store || is_check);
	assign tag.check     = is_check;
	assign tag.clr       = (is_store || is_check) && last;
	assign tag.emit      = is_check && last;
	assign tag.in_range  = 32'(atom_index) < 32'(MAX_ATOMS);
	assign tag.ctrl_fail = !list_valid_q || (count != stored_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q   <= '0;
			stored_count_q <= '0;
			list_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				case (kind_c)
					drc_pkg::KIND_STORE: begin
						list_valid_q <= 1'b0;
						if (last) begin
							stored_count_q <= count;
							list_valid_q   <= (count <= MAXC);
							pass_count_q   <= '0;
						end else begin
							pass_count_q <= count;
						end
					end
					drc_pkg::KIND_CHECK: begin
						pass_count_q <= last ? '0 : count;
					end
					drc_pkg::KIND_INVAL: begin
						list_valid_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (skin_we) begin
				list_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/drc_disp.sv]
// Displacement pipeline: abs diff (s1), half-skin test and squares (s2),
// sum and compare against skin^2/4 with the moved flag (s3).
module drc_disp #(
	parameter int POS_WIDTH = drc_pkg::DEF_POS_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       item_valid,
	input  drc_pkg::tag_t              tag,
	input  logic [3*POS_WIDTH-1:0]     pos,
	input  logic [3*POS_WIDTH-1:0]     ref_data,
	input  logic                       skin_we,
	input  logic [drc_pkg::SKIN_W-1:0] skin_wdata,
	output logic                       emit,
	output logic                       result
);

	localparam int PW = POS_WIDTH;
	localparam int CMP_W = (PW + 1 > drc_pkg::SKIN_W) ? PW + 1 : drc_pkg::SKIN_W;
	localparam logic [PW-1:0] BIAS = {1'b1, {(PW-1){1'b0}}};

	logic [drc_pkg::SKIN_W-1:0]    skin_q;
	logic [drc_pkg::SKIN_SQ_W-1:0] skin_sq_q;

	logic                    v_s1;
	drc_pkg::tag_t           tag_s1;
	logic [PW-1:0]           pos_s1 [3];
	logic [PW-1:0]           d_c [3];

	logic                    v_s2;
	drc_pkg::tag_t           tag_s2;
	logic [PW-1:0]           dx_s2 [3];
	logic                    far_c;
	logic [2*drc_pkg::SQ_W-1:0] sq_c [3];

	logic                    v_s3;
	drc_pkg::tag_t           tag_s3;
	logic                    far_s3;
	logic [2*drc_pkg::SQ_W-1:0] sq_s3 [3];

	logic [drc_pkg::SUM_W-1:0] sum_c;
	logic                    too_far;
	logic                    hit;
	logic                    moved_q;

	// skin^2 is registered; config is to be written only while idle, unchecked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skin_q    <= '0;
			skin_sq_q <= '0;
		end else begin
			if (skin_we) begin
				skin_q <= skin_wdata;
			end
			skin_sq_q <= skin_q * skin_q;
		end
	end

	// s1: absolute difference in offset binary
	always_comb begin
		logic [PW-1:0] ua;
		logic [PW-1:0] ub;
		for (int i = 0; i < 3; i++) begin
			ua = pos_s1[i] ^ BIAS;
			ub = ref_data[i*PW +: PW] ^ BIAS;
			d_c[i] = (ua > ub) ? ua - ub : ub - ua;
		end
	end

	// s2: a component beyond half skin flags at once; otherwise it fits SQ_W bits
	always_comb begin
		logic [drc_pkg::SQ_W-1:0] dn;
		far_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			dn = drc_pkg::SQ_W'(dx_s2[i]);
			if (CMP_W'({dx_s2[i], 1'b0}) > CMP_W'(skin_q)) begin
				far_c = 1'b1;
			end
			sq_c[i] = dn * dn;
		end
	end

	// s3: 4*sum > skin^2
	assign sum_c   = drc_pkg::SUM_W'(sq_s3[0]) + drc_pkg::SUM_W'(sq_s3[1])
	               + drc_pkg::SUM_W'(sq_s3[2]);
	assign too_far = drc_pkg::ACC_W'({sum_c, 2'b00}) > drc_pkg::ACC_W'(skin_sq_q);
	assign hit     = tag_s3.check && (!tag_s3.in_range || far_s3 || too_far);
	assign emit    = v_s3 && tag_s3.emit;
	assign result  = tag_s3.ctrl_fail || moved_q || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			moved_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				if (tag_s3.clr) begin
					moved_q <= 1'b0;
				end else if (hit) begin
					moved_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			far_s3 <= far_c;
			for (int i = 0; i < 3; i++) begin
				pos_s1[i] <= pos[i*PW +: PW];
				dx_s2[i]  <= d_c[i];
				sq_s3[i]  <= sq_c[i];
			end
		end
	end

endmodule

[rtl/displacement_rebuild_check.sv]
// Neighbor-list rebuild check with the half-skin rule. Each item on the slave
// stream carries one atom position (signed Q11.12) and a kind in s_tuser:
// store writes the position as the atom's reference, check compares it with
// the reference, invalidate drops list validity. A store pass ending in
// tlast marks the list valid (if its count fits the store); a check pass
// ending in tlast gives one result item, rebuild_needed, set when the list is
// invalid, the check count differs from the stored count, or any atom has
// 4*|d|^2 > skin^2. Writing skin_width also drops validity. The block takes
// one item per clock unless held off; a result is written to the output
// register after its last check item is accepted (the reference store is
// read at the accepting edge, then difference, square and sum stages, the
// sum and compare landing in the output register). Input is held off only
// while a result waits unread in the output register and another result
// reaches the end of the pipeline. The reference store powers up undefined
// and needs no clearing pass; checks of atoms never stored are meaningless.
module displacement_rebuild_check #(
	parameter int MAX_ATOMS = drc_pkg::DEF_MAX_ATOMS,
	parameter int POS_WIDTH = drc_pkg::DEF_POS_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config
	input  logic                        skin_we,
	input  logic [drc_pkg::SKIN_W-1:0]  skin_wdata,   // skin_width, Q11.12
	// slave stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// atom_index, pos_x, pos_y, pos_z, zero pad to bytes
	input  logic [((drc_pkg::IDX_W + 3*POS_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic [drc_pkg::KIND_W-1:0]  s_tuser,      // kind
	input  logic                        s_tlast,      // last
	// master stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata       // rebuild_needed, zero pad
);

	localparam int PW = POS_WIDTH;
	localparam int AW = $clog2(MAX_ATOMS);
	localparam int IW = drc_pkg::IDX_W;

	logic                    accept;
	logic                    adv;
	logic                    item_valid;
	drc_pkg::tag_t           tag;
	logic [IW-1:0]           atom_index;
	logic [3*PW-1:0]         pos;
	logic [3*PW-1:0]         ref_data;
	logic [31:0]             idx_ext;
	logic                    emit;
	logic                    result;
	logic                    out_valid_q;
	logic                    out_q;

	assign atom_index = s_tdata[IW-1:0];
	assign pos        = s_tdata[IW +: 3*PW];
	assign idx_ext    = 32'(atom_index);

	// the pipeline moves unless a finished result would overwrite an unread one
	assign adv      = !out_valid_q || m_tready || !emit;
	assign s_tready = adv;
	assign accept   = s_tvalid && s_tready;

	drc_ctrl #(
		.MAX_ATOMS (MAX_ATOMS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.kind       (s_tuser),
		.atom_index (atom_index),
		.last       (s_tlast),
		.skin_we    (skin_we),
		.item_valid (item_valid),
		.tag        (tag)
	);

	// one port serves both: a store item writes, a check item reads
	drc_ram #(
		.WIDTH (3 * PW),
		.DEPTH (MAX_ATOMS)
	) u_ref_ram (
		.clk   (clk),
		.en    (item_valid),
		.we    (!tag.check && tag.in_range),
		.addr  (idx_ext[AW-1:0]),
		.wdata (pos),
		.rdata (ref_data)
	);

	drc_disp #(
		.POS_WIDTH (PW)
	) u_disp (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item_valid (item_valid),
		.tag        (tag),
		.pos        (pos),
		.ref_data   (ref_data),
		.skin_we    (skin_we),
		.skin_wdata (skin_wdata),
		.emit       (emit),
		.result     (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q};

endmodule

[tb/displacement_rebuild_check_tb.sv]
`timescale 1ns / 1ps

module displacement_rebuild_check_tb;
	import drc_pkg::*;

	localparam int PW          = DEF_POS_WIDTH;
	localparam int NATOM       = DEF_MAX_ATOMS;
	localparam int DW          = ((IDX_W + 3 * PW + 7) / 8) * 8;
	localparam int COUNT_SAT   = NATOM + 1;
	// let the pipeline drain after the last result; leave slack before a register write
	localparam int DRAIN_CYC   = 8;
	localparam int RAND_ITEMS  = 1750;
	localparam int MIN_RESULTS = 60;
	localparam int PLAN_ROWS   = 25;
	localparam int WIDE_ROW    = 21;   // first directed row run with the widest skin

	// kind code the block must ignore
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam logic [PW-1:0]     POS_MAX    = {1'b0, {(PW-1){1'b1}}};
	localparam logic [PW-1:0]     POS_MIN    = {1'b1, {(PW-1){1'b0}}};
	localparam logic [PW-1:0]     POS_ZERO   = '0;
	localparam logic [SKIN_W-1:0] SKIN_MAX   = '1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		logic [PW-1:0]     x;
		logic [PW-1:0]     y;
		logic [PW-1:0]     z;
		logic              last;
		logic              pinned;    // result typed straight into the table
		logic              verdict;
	} atom_item_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              skin_we;
	logic [SKIN_W-1:0] skin_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [DW-1:0]     s_tdata;
	logic [KIND_W-1:0] s_tuser;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;

	// typed expectation riding along with the item on the bus
	logic              pin_on;
	logic              pin_val;

	// shadow of the block
	logic [PW-1:0]     anchor_x [NATOM];
	logic [PW-1:0]     anchor_y [NATOM];
	logic [PW-1:0]     anchor_z [NATOM];
	int unsigned       stored_cnt = 0;
	int unsigned       pass_cnt   = 0;
	bit                list_ok    = 1'b0;
	bit                moved      = 1'b0;
	logic [SKIN_W-1:0] skin_now   = '0;

	bit                rebuild_due [$];
	int unsigned       errors        = 0;
	int unsigned       verdicts_seen = 0;
	int unsigned       fed_items     = 0;
	bit                counting      = 1'b1;
	bit                calm          = 1'b0;   // no idling on either side
	int                roster [$];             // atoms of the latest store pass
	int                stall_left    = 0;
	atom_item_t        plan [PLAN_ROWS];

	displacement_rebuild_check uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.skin_we    (skin_we),
		.skin_wdata (skin_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// |a - b| of two signed positions, no wrap
	function automatic longint offset_of(logic [PW-1:0] a, logic [PW-1:0] b);
		longint d;
		d = longint'(signed'(a)) - longint'(signed'(b));
		return d < 0 ? -d : d;
	endfunction

	// half-skin rule: 4*|d|^2 > skin^2; a single large axis decides on its own
	function automatic bit beyond_half_skin(longint dx, longint dy, longint dz, longint s);
		if (2 * dx > s || 2 * dy > s || 2 * dz > s)
			return 1'b1;
		return 4 * (dx * dx + dy * dy + dz * dz) > s * s;
	endfunction

	// one accepted item through the shadow state; index is always within the store here
	task automatic predict_rebuild(input atom_item_t it, output bit gives, output bit verdict);
		int unsigned cnt;
		longint s;
		gives   = 1'b0;
		verdict = 1'b0;
		cnt = pass_cnt < COUNT_SAT ? pass_cnt + 1 : COUNT_SAT;
		s   = longint'(skin_now);
		case (it.kind)
			KIND_INVAL: list_ok = 1'b0;
			KIND_STORE: begin
				anchor_x[it.idx] = it.x;
				anchor_y[it.idx] = it.y;
				anchor_z[it.idx] = it.z;
				list_ok = 1'b0;
				if (it.last) begin
					stored_cnt = cnt;
					list_ok    = cnt <= NATOM;
					pass_cnt   = 0;
					moved      = 1'b0;
				end else begin
					pass_cnt = cnt;
				end
			end
			KIND_CHECK: begin
				if (beyond_half_skin(offset_of(it.x, anchor_x[it.idx]),
						offset_of(it.y, anchor_y[it.idx]),
						offset_of(it.z, anchor_z[it.idx]), s))
					moved = 1'b1;
				if (it.last) begin
					gives    = 1'b1;
					verdict  = !list_ok || cnt != stored_cnt || moved;
					pass_cnt = 0;
					moved    = 1'b0;
				end else begin
					pass_cnt = cnt;
				end
			end
			default: ;
		endcase
	endtask

	// bus watcher: predicts from what was really accepted, checks what comes out
	always @(posedge clk) begin : watch
		atom_item_t it;
		bit gives;
		bit verdict;
		bit want;
		if (arst_n) begin
			if (skin_we) begin
				skin_now = skin_wdata;
				list_ok  = 1'b0;
			end
			if (s_tvalid && s_tready) begin
				it      = '0;
				it.kind = s_tuser;
				it.idx  = s_tdata[IDX_W-1:0];
				it.x    = s_tdata[IDX_W +: PW];
				it.y    = s_tdata[IDX_W + PW +: PW];
				it.z    = s_tdata[IDX_W + 2 * PW +: PW];
				it.last = s_tlast;
				predict_rebuild(it, gives, verdict);
				if (gives)
					rebuild_due.push_back(pin_on ? pin_val : verdict);
			end
			if (m_tvalid && m_tready) begin
				if (rebuild_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got rebuild_needed=%0d",
						$time, m_tdata[0]);
				end else begin
					want = rebuild_due.pop_front();
					verdicts_seen++;
					if (m_tdata[0] !== want) begin
						errors++;
						$display("%0t: rebuild_needed expected %0d, got %0d",
							$time, want, m_tdata[0]);
					end
				end
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	// result side back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send(input atom_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tlast  <= it.last;
		s_tdata  <= DW'({it.z, it.y, it.x, it.idx});
		pin_on   <= it.pinned;
		pin_val  <= it.verdict;
		do
			@(posedge clk);
		while (!s_tready);
		if (counting && (it.kind == KIND_STORE || it.kind == KIND_CHECK))
			fed_items++;
		@(negedge clk);
	endtask

	// hold the input until every result is out and the pipeline has emptied
	task automatic settle();
		s_tvalid <= 1'b0;
		while (rebuild_due.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	task automatic set_skin(input logic [SKIN_W-1:0] v);
		settle();
		skin_we    <= 1'b1;
		skin_wdata <= v;
		@(negedge clk);
		skin_we    <= 1'b0;
	endtask

	function automatic longint spread(longint lim);
		return longint'($urandom_range(0, 32'(2 * lim))) - lim;
	endfunction

	// new position for a stored atom, spread around the half-skin boundary
	task automatic drift(input int idx, output logic [PW-1:0] x, output logic [PW-1:0] y,
			output logic [PW-1:0] z);
		longint h;
		longint s;
		longint a;
		longint b;
		longint d [3];
		int mode;
		int ax;
		s = longint'(skin_now);
		h = s / 2;
		d = '{0, 0, 0};
		mode = $urandom_range(0, 9);
		ax   = $urandom_range(0, 2);
		if (mode < 5) begin
			// well inside the sphere
			for (int i = 0; i < 3; i++)
				d[i] = spread(h / 2);
		end else if (mode < 7) begin
			// one axis on the boundary, one step either side
			d[ax] = h + $urandom_range(0, 2) - 1;
		end else if (mode < 8) begin
			// two axes near the circle of radius half skin
			a = $urandom_range(0, 32'(h));
			b = longint'($floor($sqrt(real'(s) * real'(s) / 4.0 - real'(a) * real'(a))));
			d[ax] = a;
			d[(ax + 1) % 3] = b + $urandom_range(0, 2) - 1;
		end else if (mode < 9) begin
			for (int i = 0; i < 3; i++)
				d[i] = spread(longint'(1) << 22);
		end else begin
			x = PW'($urandom);
			y = PW'($urandom);
			z = PW'($urandom);
			return;
		end
		for (int i = 0; i < 3; i++)
			if ($urandom_range(0, 1))
				d[i] = -d[i];
		x = anchor_x[idx] + d[0][PW-1:0];
		y = anchor_y[idx] + d[1][PW-1:0];
		z = anchor_z[idx] + d[2][PW-1:0];
	endtask

	task automatic store_pass(input int n);
		atom_item_t it;
		roster.delete();
		for (int i = 0; i < n; i++) begin
			it      = '0;
			it.kind = KIND_STORE;
			it.idx  = $urandom_range(0, NATOM - 1);
			it.x    = PW'($urandom);
			it.y    = PW'($urandom);
			it.z    = PW'($urandom);
			it.last = (i == n - 1);
			roster.push_back(it.idx);
			send(it);
		end
	endtask

	// stores more atoms than the store holds: count saturates, list stays invalid
	task automatic flood();
		atom_item_t it;
		calm     = 1'b1;
		counting = 1'b0;
		for (int i = 0; i <= NATOM; i++) begin
			it      = '0;
			it.kind = KIND_STORE;
			it.idx  = IDX_W'(i % NATOM);
			it.x    = PW'($urandom);
			it.y    = PW'($urandom);
			it.z    = PW'($urandom);
			it.last = (i == NATOM);
			send(it);
		end
		counting = 1'b1;
		roster.delete();
		repeat (8) roster.push_back($urandom_range(0, NATOM - 1));
	endtask

	// one pass over the roster, mostly well formed, with some noise mixed in
	task automatic check_pass();
		atom_item_t it;
		atom_item_t stray;
		int order [$];
		int r;
		order = roster;
		if ($urandom_range(0, 1))
			order.shuffle();
		r = $urandom_range(0, 9);
		if (r == 0 && order.size() > 1)
			void'(order.pop_back());
		else if (r == 1)
			order.push_back(roster[$urandom_range(0, roster.size() - 1)]);
		for (int j = 0; j < order.size(); j++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				stray      = '0;
				stray.idx  = $urandom_range(0, NATOM - 1);
				stray.x    = PW'($urandom);
				stray.y    = PW'($urandom);
				stray.z    = PW'($urandom);
				stray.last = $urandom_range(0, 1);
				if (r < 3)
					stray.kind = KIND_INVAL;
				else if (r < 5)
					stray.kind = KIND_SPARE;
				else
					stray.kind = KIND_STORE;   // store dropped into the middle of a check
				send(stray);
			end else if (r < 9) begin
				settle();
			end
			it      = '0;
			it.kind = KIND_CHECK;
			it.idx  = order[j];
			drift(order[j], it.x, it.y, it.z);
			it.last = (j == order.size() - 1);
			send(it);
		end
	endtask

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		bit flooded;
		int r;
		flooded    = 1'b0;
		arst_n     = 1'b0;
		skin_we    = 1'b0;
		skin_wdata = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		s_tlast    = 1'b0;
		m_tready   = 1'b0;
		pin_on     = 1'b0;
		pin_val    = 1'b0;

		// kind, atom, x, y, z, last, typed, rebuild
		plan = '{
			// ignored kind, then an invalidate whose last flag means nothing
			'{KIND_SPARE, 12'hFFF, POS_MAX, POS_MIN, POS_MAX, 1'b1, 1'b0, 1'b0},
			'{KIND_INVAL, 12'd0, POS_ZERO, POS_ZERO, POS_ZERO, 1'b1, 1'b0, 1'b0},
			// skin still zero from reset: standing still passes, one LSB fails
			'{KIND_STORE, 12'd0, POS_ZERO, POS_ZERO, POS_ZERO, 1'b1, 1'b0, 1'b0},
			'{KIND_CHECK, 12'd0, POS_ZERO, POS_ZERO, POS_ZERO, 1'b1, 1'b1, 1'b0},
			'{KIND_CHECK, 12'd0, 24'd1, POS_ZERO, POS_ZERO, 1'b1, 1'b1, 1'b1},
			// positions at full scale, three atoms
			'{KIND_STORE, 12'hFFF, POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b0, 1'b0},
			'{KIND_STORE, 12'd1, POS_MIN, POS_MIN, POS_MIN, 1'b0, 1'b0, 1'b0},
			'{KIND_STORE, 12'd2, POS_ZERO, POS_ZERO, POS_ZERO, 1'b1, 1'b0, 1'b0},
			'{KIND_CHECK, 12'hFFF, POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b0, 1'b0},
			'{KIND_CHECK, 12'd1, POS_MIN, POS_MIN, POS_MIN, 1'b0, 1'b0, 1'b0},
			'{KIND_CHECK, 12'd2, POS_ZERO, POS_ZERO, POS_ZERO, 1'b1, 1'b1, 1'b0},
			// swing from one end of the range to the other
			'{KIND_CHECK, 12'd1, POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b0, 1'b0},
			'{KIND_CHECK, 12'hFFF, POS_MIN, POS_MIN, POS_MIN, 1'b0, 1'b0, 1'b0},
			'{KIND_CHECK, 12'd2, POS_ZERO, POS_ZERO, POS_ZERO, 1'b1, 1'b1, 1'b1},
			// pass shorter than the store
			'{KIND_CHECK, 12'd2, POS_ZERO, POS_ZERO, POS_ZERO, 1'b1, 1'b1, 1'b1},
			// right count and no motion, but the list was invalidated
			'{KIND_INVAL, 12'd0, POS_ZERO, POS_ZERO, POS_ZERO, 1'b0, 1'b0, 1'b0},
			'{KIND_CHECK, 12'hFFF, POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b0, 1'b0},
			'{KIND_CHECK, 12'd1, POS_MIN, POS_MIN, POS_MIN, 1'b0, 1'b0, 1'b0},
			'{KIND_CHECK, 12'd2, POS_ZERO, POS_ZERO, POS_ZERO, 1'b1, 1'b1, 1'b1},
			// store left open, then a check closes the mixed pass
			'{KIND_STORE, 12'd2, POS_ZERO, POS_ZERO, POS_ZERO, 1'b0, 1'b0, 1'b0},
			'{KIND_CHECK, 12'd2, POS_ZERO, POS_ZERO, POS_ZERO, 1'b1, 1'b1, 1'b1},
			// widest skin: one axis either side of half skin
			'{KIND_STORE, 12'd0, POS_ZERO, POS_ZERO, POS_ZERO, 1'b1, 1'b0, 1'b0},
			'{KIND_CHECK, 12'd0, 24'h3FFFFF, POS_ZERO, POS_ZERO, 1'b1, 1'b0, 1'b0},
			'{KIND_CHECK, 12'd0, 24'h400000, POS_ZERO, POS_ZERO, 1'b1, 1'b0, 1'b0},
			'{KIND_CHECK, 12'd0, POS_ZERO, 24'hC00001, POS_ZERO, 1'b1, 1'b0, 1'b0}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (i == WIDE_ROW)
				set_skin(SKIN_MAX);
			send(plan[i]);
		end

		// random phases: new skin, a store pass, several check passes over it
		while (fed_items < RAND_ITEMS || verdicts_seen < MIN_RESULTS || !flooded) begin
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0: set_skin('0);
				1: set_skin(SKIN_MAX);
				2: set_skin(SKIN_W'(1));
				3: set_skin(SKIN_W'($urandom_range(2, 4095)));
				default: set_skin(SKIN_W'($urandom));
			endcase
			if (!flooded && fed_items > RAND_ITEMS / 3) begin
				flood();
				flooded = 1'b1;
				calm = 1'b0;
				check_pass();
			end
			r = $urandom_range(0, 99);
			if (r < 80)
				store_pass($urandom_range(1, 16));
			else if (r < 95)
				store_pass($urandom_range(17, 64));
			else
				store_pass($urandom_range(65, 300));
			repeat ($urandom_range(2, 6)) check_pass();
		end

		settle();
		repeat (4 * DRAIN_CYC) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/drc_pkg.sv
rtl/drc_ram.sv
rtl/drc_ctrl.sv
rtl/drc_disp.sv
rtl/displacement_rebuild_check.sv
tb/displacement_rebuild_check_tb.sv
